// ===== sv/md5rw_pkg.sv =====
// ----------------------------------------------------------------------------
// md5rw_pkg
// Shared types, step constants and helper functions for the keyed MD5-step
// timestamp scrambler.
// ----------------------------------------------------------------------------
package md5rw_pkg;

    localparam int unsigned NumSteps = 64;

    // Standard MD5 initial chaining values
    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hefcdab89;
    localparam logic [31:0] InitC = 32'h98badcfe;
    localparam logic [31:0] InitD = 32'h10325476;

    // Additive constant of each step
    localparam logic [31:0] StepConst [NumSteps] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amount, indexed by {round, step[1:0]}
    localparam logic [4:0] RotAmount [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Round codes
    typedef enum logic [1:0] {
        RND_F = 2'd0,
        RND_G = 2'd1,
        RND_H = 2'd2,
        RND_I = 2'd3
    } t_round;

    // One pipeline slot: valid bit, working words and the timestamp bytes
    typedef struct packed {
        logic        valid;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] sec;
        logic [31:0] usec;
    } t_md5rw_stage;

    // Message byte index used by a step
    function automatic logic [3:0] msg_index(input logic [5:0] step);
        logic [3:0] i4;
        logic [3:0] idx;
        i4 = step[3:0];
        unique case (t_round'(step[5:4]))
            RND_F:   idx = i4;
            RND_G:   idx = 4'd1 + 4'(i4 * 4'd5);
            RND_H:   idx = 4'd5 + 4'(i4 * 4'd3);
            RND_I:   idx = 4'(i4 * 4'd7);
            default: idx = i4;
        endcase
        return idx;
    endfunction

    // Left rotate by 0..31
    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] w;
        w = {v, v} << s;
        return w[63:32];
    endfunction

endpackage

// ===== sv/md5_round_random_word.sv =====
// ----------------------------------------------------------------------------
// md5_round_random_word
// Keyed timestamp scrambler: 64 MD5 steps over key and timestamp bytes,
// result is the XOR of the four working words.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  word
//  command   in         start & !busy              i_time_seconds, i_time_micro
//  result    out        o_strobe (one cycle)       o_random_word
//  config    in         i_cfg_valid & o_cfg_ready  i_cfg_data (secret key)
//
// One command word is taken every cycle; busy stays low.
// Each command passes through one register stage per MD5 step, then the output
// register holding the XOR fold.
// Synchronous active-low reset clears the valid bits and the key.
// The receiver cannot stall; the pipeline never holds.
// ----------------------------------------------------------------------------
module md5_round_random_word
    import md5rw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_time_seconds,
    input  logic [31:0] i_time_micro,
    output logic        o_strobe,
    output logic [31:0] o_random_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data
);

    localparam int unsigned Latency = NumSteps + 1;

    t_md5rw_stage stage [NumSteps + 1];
    logic [63:0]  r_secret_key;
    logic         r_strobe;
    logic [31:0]  r_random_word;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Hold the key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secret_key <= 64'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_secret_key <= i_cfg_data;
        end
    end

    // Load the first stage with the initial chaining values
    assign stage[0] = '{valid: start && !busy, a: InitA, b: InitB, c: InitC,
                        d: InitD, sec: i_time_seconds, usec: i_time_micro};

    // One register stage per step
    for (genvar g = 0; g < NumSteps; g++) begin : g_step
        md5rw_step u_step (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_step       (6'(g)),
            .i_secret_key (r_secret_key),
            .i_stage      (stage[g]),
            .o_stage      (stage[g+1])
        );
    end

    // Fold the working words into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= stage[NumSteps].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_random_word <= stage[NumSteps].a ^ stage[NumSteps].b
                       ^ stage[NumSteps].c ^ stage[NumSteps].d;
    end

    assign o_strobe      = r_strobe;
    assign o_random_word = r_random_word;

    // A strobe needs a command accepted exactly one latency earlier
    a_strobe_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, Latency))
        else $error("result strobe without matching command");

    // Every accepted command yields a strobe after the full latency
    a_cmd_gives_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##Latency o_strobe)
        else $error("accepted command lost in pipeline");

    // The last step stage feeds the strobe in the next cycle
    a_last_stage_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage[NumSteps].valid |=> o_strobe)
        else $error("final stage valid not forwarded");

endmodule

// ===== sv/md5rw_step.sv =====
// ----------------------------------------------------------------------------
// md5rw_step
// One MD5 step as a register stage: round function, byte message word,
// constant add, rotate and add, then rotate the working words.
// ----------------------------------------------------------------------------
module md5rw_step
    import md5rw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [5:0]   i_step,
    input  logic [63:0]  i_secret_key,
    input  t_md5rw_stage i_stage,
    output t_md5rw_stage o_stage
);

    logic [31:0]  f;
    logic [127:0] msg;
    logic [7:0]   msg_byte;
    logic [3:0]   rot_sel;
    logic [31:0]  sum;
    logic [31:0]  n_b;
    logic         r_valid;
    logic [31:0]  r_a;
    logic [31:0]  r_b;
    logic [31:0]  r_c;
    logic [31:0]  r_d;
    logic [31:0]  r_sec;
    logic [31:0]  r_usec;

    // Pick the round function
    always_comb begin
        unique case (t_round'(i_step[5:4]))
            RND_F:   f = i_stage.d ^ (i_stage.b & (i_stage.c ^ i_stage.d));
            RND_G:   f = i_stage.c ^ (i_stage.d & (i_stage.b ^ i_stage.c));
            RND_H:   f = i_stage.b ^ i_stage.c ^ i_stage.d;
            RND_I:   f = i_stage.c ^ (i_stage.b | ~i_stage.d);
            default: f = i_stage.b ^ i_stage.c ^ i_stage.d;
        endcase
    end

    // Message: key bytes first, then seconds, then microseconds
    assign msg      = {i_stage.usec, i_stage.sec, i_secret_key};
    assign msg_byte = msg[{msg_index(i_step), 3'b000} +: 8];
    assign rot_sel  = {i_step[5:4], i_step[1:0]};

    // Add, rotate, add
    assign sum = i_stage.a + f + {24'd0, msg_byte} + StepConst[i_step];
    assign n_b = rotl32(sum, RotAmount[rot_sel]) + i_stage.b;

    // Advance valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_a    <= i_stage.d;
        r_b    <= n_b;
        r_c    <= i_stage.b;
        r_d    <= i_stage.c;
        r_sec  <= i_stage.sec;
        r_usec <= i_stage.usec;
    end

    assign o_stage = '{valid: r_valid, a: r_a, b: r_b, c: r_c, d: r_d,
                       sec: r_sec, usec: r_usec};

endmodule
